// ===== design/assert_macros.svh =====
// Assertion macros included by the sorted priority queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/spq_pkg.sv =====
// Package: sizes, codes and word types of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(DEPTH + 1);
    localparam int CFG_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [1:0] CMD_ENQUEUE     = 2'd0;
    localparam logic [1:0] CMD_REMOVE_HEAD = 2'd1;
    localparam logic [1:0] CMD_REMOVE_EQ   = 2'd2;
    localparam logic [1:0] CMD_REMOVE_GE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic [1:0]               command;
        logic [PRIORITY_BITS-1:0] priority_req;
        logic [PAYLOAD_BITS-1:0]  payload;
    } spq_request_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [PAYLOAD_BITS-1:0]  out_payload;
        logic [COUNT_BITS-1:0]    occupancy;
        logic                     is_empty;
    } spq_result_t;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  data;
    } spq_entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                     enq_go;
        logic                     rem_go;
        logic [1:0]               command;
        spq_entry_t               req;
    } spq_ctrl_t;

    // Compare results of one cell, seen by its neighbors and the controller.
    typedef struct packed {
        logic gt;
        logic eq;
        logic ge;
        logic sel;
    } spq_flags_t;

endpackage

// ===== design/sorted_priority_queue_unit.sv =====
// Top level: sorted priority queue built as a chain of compare-and-shift cells.
//
// The queue takes one command in every clock cycle: busy stays low, and the result word
// for a command accepted at one edge is on result for the following cycle, marked by done.
// Every cell compares its own entry with the request in parallel and loads the request
// or its left or right neighbor's entry, so each command, enqueue or removal, completes
// at its accepting edge, at one command per cycle. The receiver cannot stall.
// Configuration writes on cfg_write are registered; slot contents are undefined until
// written and only slots below the occupancy count are ever read.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  spq_request_t            request,
    output logic                    done,
    output spq_result_t             result,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    logic [PRIORITY_BITS-1:0] low_limit_reg;
    logic [PRIORITY_BITS-1:0] high_limit_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic                     done_reg;
    spq_result_t              result_reg;
    spq_result_t              result_next;

    logic                     accept;
    logic                     in_limits;
    logic                     found;
    spq_ctrl_t                ctrl;
    spq_entry_t               entries [DEPTH];
    spq_flags_t               flags   [DEPTH];
    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         eq_vec;
    logic [DEPTH-1:0]         sel_vec;
    spq_entry_t               removed;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_limits = (request.priority_req >= low_limit_reg)
                    && (request.priority_req <= high_limit_reg);

    always_comb
    begin
        case (request.command)
            CMD_REMOVE_HEAD: found = (count_reg != '0);
            CMD_REMOVE_EQ:   found = |eq_vec;
            CMD_REMOVE_GE:   found = flags[0].ge;
            default:         found = 1'b0;
        endcase
    end

    assign ctrl.command  = request.command;
    assign ctrl.req.prio = request.priority_req;
    assign ctrl.req.data = request.payload;
    assign ctrl.enq_go   = accept && (request.command == CMD_ENQUEUE) && in_limits
                        && (count_reg < COUNT_BITS'(DEPTH));
    assign ctrl.rem_go   = accept && (request.command != CMD_ENQUEUE) && found;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            assign occ[k]     = COUNT_BITS'(k) < count_reg;
            assign eq_vec[k]  = flags[k].eq;
            assign sel_vec[k] = flags[k].sel;

            if (k == 0)
            begin : g_first
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occ         (occ[k]),
                    .head        (1'b1),
                    .left_gt     (1'b1),
                    .left_eq     (1'b0),
                    .right_ge    (flags[k+1].ge),
                    .left_entry  (ctrl.req),
                    .right_entry (entries[k+1]),
                    .entry       (entries[k]),
                    .flags       (flags[k])
                );
            end
            else if (k == DEPTH - 1)
            begin : g_last
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occ         (occ[k]),
                    .head        (1'b0),
                    .left_gt     (flags[k-1].gt),
                    .left_eq     (flags[k-1].eq),
                    .right_ge    (1'b0),
                    .left_entry  (entries[k-1]),
                    .right_entry ('0),
                    .entry       (entries[k]),
                    .flags       (flags[k])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occ         (occ[k]),
                    .head        (1'b0),
                    .left_gt     (flags[k-1].gt),
                    .left_eq     (flags[k-1].eq),
                    .right_ge    (flags[k+1].ge),
                    .left_entry  (entries[k-1]),
                    .right_entry (entries[k+1]),
                    .entry       (entries[k]),
                    .flags       (flags[k])
                );
            end
        end
    endgenerate

    // select the removed word: at most one cell raises sel
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                removed = removed | entries[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq_go)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (ctrl.rem_go)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        result_next              = '0;
        result_next.occupancy    = count_next;
        result_next.is_empty     = (count_next == '0);
        if (request.command == CMD_ENQUEUE)
        begin
            if (!in_limits)
            begin
                result_next.status = ST_LIMIT;
            end
            else if (!ctrl.enq_go)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                result_next.status = ST_OK;
            end
        end
        else if (found)
        begin
            result_next.status       = ST_OK;
            result_next.out_priority = removed.prio;
            result_next.out_payload  = removed.data;
        end
        else
        begin
            result_next.status = ST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= '0;
            high_limit_reg <= '1;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_LOW_LIMIT))
            begin
                low_limit_reg <= cfg_data[PRIORITY_BITS-1:0];
            end
            if (cfg_write && (cfg_index == REG_HIGH_LIMIT))
            begin
                high_limit_reg <= cfg_data[PRIORITY_BITS-1:0];
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `include "assert_macros.svh"

    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= COUNT_BITS'(DEPTH), "count above depth")
    `SPQ_ASSERT_NEXT(a_done_follows, accept, done, "accepted command gave no result")
    `SPQ_ASSERT_NEXT(a_no_stray_done, !accept, !done, "result without a command")
    `SPQ_ASSERT_SAME(a_empty_flag, done, result.is_empty == (result.occupancy == '0), "empty flag")
    `SPQ_ASSERT_SAME(a_one_select, 1'b1, $onehot0(sel_vec), "more than one cell selected")
    `SPQ_ASSERT_NEXT(a_enq_count, ctrl.enq_go, count_reg == $past(count_reg) + COUNT_BITS'(1), "enqueue count")

endmodule

// ===== design/spq_cell.sv =====
// One slot of the sorted chain: compare against the request and shift.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_ctrl_t  ctrl,
    input  logic       occ,
    input  logic       head,
    input  logic       left_gt,
    input  logic       left_eq,
    input  logic       right_ge,
    input  spq_entry_t left_entry,
    input  spq_entry_t right_entry,
    output spq_entry_t entry,
    output spq_flags_t flags
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       gt;
    logic       eq;
    logic       ge;
    logic       sel;
    logic       shift_out;

    assign gt = occ && (entry_reg.prio > ctrl.req.prio);
    assign eq = occ && (entry_reg.prio == ctrl.req.prio);
    assign ge = occ && (entry_reg.prio >= ctrl.req.prio);

    always_comb
    begin
        case (ctrl.command)
            CMD_REMOVE_HEAD:
            begin
                sel       = head && occ;
                shift_out = 1'b1;
            end
            CMD_REMOVE_EQ:
            begin
                // equal entries are contiguous: the first one follows a non-match
                sel       = eq && !left_eq;
                shift_out = !gt;
            end
            CMD_REMOVE_GE:
            begin
                // entries at or above the threshold form a prefix: take its end
                sel       = ge && !right_ge;
                shift_out = !right_ge;
            end
            default:
            begin
                sel       = 1'b0;
                shift_out = 1'b0;
            end
        endcase
    end

    assign flags.gt  = gt;
    assign flags.eq  = eq;
    assign flags.ge  = ge;
    assign flags.sel = sel;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq_go && !gt)
        begin
            entry_next = left_gt ? ctrl.req : left_entry;
        end
        else if (ctrl.rem_go && shift_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
